// File: rtl/mha_pkg.sv
// Shared types, constants and a helper function of the member hunt arbiter.
`default_nettype none

package mha_pkg;

    // Fixed field widths of the hunt request, result and configuration, and the default member limit.
    localparam int MASK_W          = 16;
    localparam int IDX_W           = 4;
    localparam int COUNT_W         = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 5;
    localparam int MAX_MEMBERS_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HUNT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_COUNT = 2'd1;

    // Hunt mode values.
    localparam logic MODE_SEQUENTIAL = 1'b0;
    localparam logic MODE_CYCLIC     = 1'b1;

    // Result outcome codes.
    typedef enum logic [1:0] {
        OUT_GRANT = 2'd0,
        OUT_EMPTY = 2'd1,
        OUT_STOP  = 2'd2,
        OUT_NONE  = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [MASK_W-1:0] ready_mask;
        logic [MASK_W-1:0] busy_mask;
        logic [MASK_W-1:0] registered_mask;
        logic              resume_valid;
        logic [IDX_W-1:0]  resume_index;
        logic              stop_valid;
        logic [IDX_W-1:0]  stop_index;
    } t_hunt_req;

    typedef struct packed {
        t_outcome         outcome;
        logic [IDX_W-1:0] grant_index;
    } t_hunt_res;

    typedef struct packed {
        logic               hunt_mode;
        logic [COUNT_W-1:0] member_count;
    } t_hunt_cfg;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } t_grant_rec;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } t_first;

    // Lowest set bit of a member vector.
    function automatic t_first first_set(input logic [MASK_W-1:0] vec);
        t_first res;
        res.found = 1'b0;
        res.index = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (vec[i]) begin
                res.found = 1'b1;
                res.index = IDX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mha_req_if.sv
// Hunt request channel: valid, ready and the request fields.
`default_nettype none

interface mha_req_if;
    logic                          valid;
    logic                          ready;
    logic [mha_pkg::MASK_W-1:0]    ready_mask;
    logic [mha_pkg::MASK_W-1:0]    busy_mask;
    logic [mha_pkg::MASK_W-1:0]    registered_mask;
    logic                          resume_valid;
    logic [mha_pkg::IDX_W-1:0]     resume_index;
    logic                          stop_valid;
    logic [mha_pkg::IDX_W-1:0]     stop_index;

    modport source (
        output valid, ready_mask, busy_mask, registered_mask,
               resume_valid, resume_index, stop_valid, stop_index,
        input  ready
    );
    modport sink (
        input  valid, ready_mask, busy_mask, registered_mask,
               resume_valid, resume_index, stop_valid, stop_index,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/mha_res_if.sv
// Hunt result channel: valid, ready and the result fields.
`default_nettype none

interface mha_res_if;
    logic                      valid;
    logic                      ready;
    mha_pkg::t_outcome         outcome;
    logic [mha_pkg::IDX_W-1:0] grant_index;

    modport source (
        output valid, outcome, grant_index,
        input  ready
    );
    modport sink (
        input  valid, outcome, grant_index,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/member_hunt_arbiter_unit.sv
// Top level of the member hunt arbiter: channels, configuration and grant record.
//
// Usage:
//   Hunt requests arrive on i_req and results leave on o_res, both valid/ready
//   channels; an item moves at a rising edge with valid and ready high.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data:
//   index 0 is the hunt mode, index 1 the member count. Writes to other
//   indexes are ignored. Write only while no request is in flight.
//   Each request yields exactly one result. A request is held in the input
//   register, searched by a single combinational pass, and its result is
//   registered in the result register, which loads it once that register is
//   free. One request is taken per cycle while results are taken; the rate
//   is set by the input register feeding the output register, with the
//   grant record updated on the same edge that loads the result.
//   When the receiver stalls, the result register holds its item and the
//   input register can still take one more request; after that i_req.ready
//   drops until the result is taken.
//   Reset clears both channels, the grant record and the configuration.
`default_nettype none

module member_hunt_arbiter_unit #(
    parameter int MAX_MEMBERS = mha_pkg::MAX_MEMBERS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [mha_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mha_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mha_req_if.sink                               i_req,
    mha_res_if.source                             o_res
);

    mha_pkg::t_hunt_cfg  r_cfg;
    mha_pkg::t_grant_rec r_rec;
    mha_pkg::t_hunt_req  r_s1;
    logic                r_s1_valid;
    mha_pkg::t_hunt_res  r_out;
    logic                r_out_valid;
    mha_pkg::t_hunt_req  req;
    mha_pkg::t_hunt_res  n_out;
    logic                out_free;
    logic                s1_move;
    logic                in_take;

    // Handshake: the output register frees the input register.
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_move     = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || out_free;
    assign in_take     = i_req.valid && i_req.ready;

    assign req.ready_mask      = i_req.ready_mask;
    assign req.busy_mask       = i_req.busy_mask;
    assign req.registered_mask = i_req.registered_mask;
    assign req.resume_valid    = i_req.resume_valid;
    assign req.resume_index    = i_req.resume_index;
    assign req.stop_valid      = i_req.stop_valid;
    assign req.stop_index      = i_req.stop_index;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mha_pkg::CFG_HUNT_MODE:    r_cfg.hunt_mode    <= i_cfg_data[0];
                mha_pkg::CFG_MEMBER_COUNT: r_cfg.member_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
        if (in_take) begin
            r_s1 <= req;
        end
    end

    mha_hunt_core #(
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_core (
        .i_cfg (r_cfg),
        .i_req (r_s1),
        .i_rec (r_rec),
        .o_res (n_out)
    );

    // Result register and grant record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rec       <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_move && (n_out.outcome == mha_pkg::OUT_GRANT)) begin
                r_rec.valid <= 1'b1;
                r_rec.index <= n_out.grant_index;
            end
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.outcome     = r_out.outcome;
    assign o_res.grant_index = r_out.grant_index;

endmodule

`default_nettype wire

// File: rtl/mha_hunt_core.sv
// Combinational hunt: eligibility, start member and rotated priority search.
`default_nettype none

module mha_hunt_core #(
    parameter int MAX_MEMBERS = mha_pkg::MAX_MEMBERS_DEF
) (
    input  mha_pkg::t_hunt_cfg  i_cfg,
    input  mha_pkg::t_hunt_req  i_req,
    input  mha_pkg::t_grant_rec i_rec,
    output mha_pkg::t_hunt_res  o_res
);

    logic [mha_pkg::COUNT_W-1:0] count;
    logic [mha_pkg::MASK_W-1:0]  in_range;
    logic [mha_pkg::MASK_W-1:0]  elig;
    logic [mha_pkg::MASK_W-1:0]  stop_vec;
    logic [mha_pkg::MASK_W-1:0]  hit;
    logic [mha_pkg::MASK_W-1:0]  upper;
    logic                        resume_ok;
    logic                        rec_ok;
    logic [mha_pkg::IDX_W-1:0]   base;
    logic [mha_pkg::COUNT_W-1:0] next_pos;
    logic [mha_pkg::COUNT_W-1:0] start5;
    logic [mha_pkg::IDX_W-1:0]   start;
    mha_pkg::t_first             first_hi;
    mha_pkg::t_first             first_all;
    logic [mha_pkg::IDX_W-1:0]   pos;

    // Effective member count, saturated to the group limit.
    always_comb begin
        if (32'(i_cfg.member_count) > MAX_MEMBERS) begin
            count = mha_pkg::COUNT_W'(MAX_MEMBERS);
        end else begin
            count = i_cfg.member_count;
        end
    end

    // Members inside the group and eligible for a grant.
    always_comb begin
        for (int i = 0; i < mha_pkg::MASK_W; i++) begin
            in_range[i] = (mha_pkg::COUNT_W'(i) < count);
        end
        elig = i_req.ready_mask & ~i_req.busy_mask & i_req.registered_mask & in_range;
    end

    // Stop member, only when it lies inside the group.
    always_comb begin
        stop_vec = '0;
        if (i_req.stop_valid && ({1'b0, i_req.stop_index} < count)) begin
            stop_vec[i_req.stop_index] = 1'b1;
        end
        hit = elig | stop_vec;
    end

    // Start member: after the resume member, else after the last grant in cyclic mode, else member zero.
    always_comb begin
        resume_ok = i_req.resume_valid && ({1'b0, i_req.resume_index} < count);
        rec_ok    = (i_cfg.hunt_mode == mha_pkg::MODE_CYCLIC) && i_rec.valid &&
                    ({1'b0, i_rec.index} < count);
        base      = resume_ok ? i_req.resume_index : i_rec.index;
        next_pos  = {1'b0, base} + mha_pkg::COUNT_W'(1);
        if (!(resume_ok || rec_ok) || (next_pos == count)) begin
            start5 = '0;
        end else begin
            start5 = next_pos;
        end
        // A start past the masked members behaves as a start at member zero.
        start = start5[mha_pkg::COUNT_W-1] ? '0 : start5[mha_pkg::IDX_W-1:0];
    end

    // Rotated priority search: first hit at or above the start, else first hit overall.
    always_comb begin
        for (int i = 0; i < mha_pkg::MASK_W; i++) begin
            upper[i] = (mha_pkg::IDX_W'(i) >= start);
        end
        first_hi  = mha_pkg::first_set(hit & upper);
        first_all = mha_pkg::first_set(hit);
        pos       = first_hi.found ? first_hi.index : first_all.index;
    end

    // Outcome; the stop test wins over eligibility at the same member.
    always_comb begin
        o_res.grant_index = '0;
        if (count == '0) begin
            o_res.outcome = mha_pkg::OUT_EMPTY;
        end else if (!first_all.found) begin
            o_res.outcome = mha_pkg::OUT_NONE;
        end else if (stop_vec[pos]) begin
            o_res.outcome = mha_pkg::OUT_STOP;
        end else begin
            o_res.outcome     = mha_pkg::OUT_GRANT;
            o_res.grant_index = pos;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mha_checker.sv
// Port-level checks of the member hunt arbiter and their binding to the top level.
`default_nettype none

module mha_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [1:0]                i_outcome,
    input wire logic [mha_pkg::IDX_W-1:0] i_grant_index
);

    // A stalled result keeps its item.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_outcome) && $stable(i_grant_index))
        else $error("result item changed while stalled");

    // Only a grant carries a nonzero member index.
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_outcome != mha_pkg::OUT_GRANT) |-> i_grant_index == '0)
        else $error("grant index set without a grant");

    // Requests are refused only behind a stalled result.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("request refused without output stall");

    // An accepted request reaches the output register once the output is free.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready |=> i_out_valid)
        else $error("result item missing after request");

endmodule

bind member_hunt_arbiter_unit mha_checker u_mha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_outcome     (o_res.outcome),
    .i_grant_index (o_res.grant_index)
);

`default_nettype wire
